[hdl/cpd_pkg.sv]
package cpd_pkg;

   localparam int MAX_PAYLOAD_DEF = 32;
   localparam int HDR_LEN         = 3;

   localparam logic [7:0]  SYNC_RESET = 8'h55;
   localparam logic [15:0] SEED_RESET = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

   localparam logic [1:0] ST_GOOD = 2'd0;
   localparam logic [1:0] ST_CRC  = 2'd1;
   localparam logic [1:0] ST_LEN  = 2'd2;

   localparam logic CSR_SYNC = 1'b0;
   localparam logic CSR_SEED = 1'b1;

   typedef struct packed {
      logic        load_seed;
      logic        start;
      logic [15:0] seed;
      logic [7:0]  data;
   } crc_ctrl_type;

   function automatic logic [15:0] crc_shift(input logic [15:0] c);
      logic [15:0] s;
      s = {c[14:0], 1'b0};
      if (c[15]) begin
         s = s ^ CRC_POLY;
      end
      return s;
   endfunction

endpackage

[hdl/cpd_crc_unit.sv]
module cpd_crc_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  cpd_pkg::crc_ctrl_type ctrl,
   output logic                 busy,
   output logic [15:0]          crc
);

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  count_ff, count_in;
   logic        busy_ff, busy_in;

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (ctrl.load_seed) begin
         crc_in = ctrl.seed;
      end else if (ctrl.start) begin
         crc_in   = crc_ff ^ {ctrl.data, 8'h00};
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         crc_in   = cpd_pkg::crc_shift(crc_ff);
         count_in = count_ff + 3'd1;
         if (count_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= cpd_pkg::SEED_RESET;
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign crc  = crc_ff;

endmodule

[hdl/cpd_payload_ram.sv]
module cpd_payload_ram #(
   parameter int DEPTH = cpd_pkg::MAX_PAYLOAD_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/crc_checked_packet_deframer_unit.sv]
// Byte-stream frame receiver: sync, length L, control, L-3 payload bytes, then a
// big-endian CRC-16-CCITT (0x1021, MSB first, seeded from csr register 1 at each
// sync) over the payload. Header, CRC and timeout requests skip the CRC unit;
// each payload byte starts it, and the CRC is folded in one bit a cycle by a
// bit-serial shift/xor unit, with req_stall high meanwhile. A good frame then
// streams its payload from the on-chip payload memory at one byte per cycle
// while rsp_stall is low, behind the memory's registered read, with req_stall
// high until the last byte is in the output register. Length and CRC errors
// give a single response. The payload memory needs no clearing pass after reset.
module crc_checked_packet_deframer_unit #(
   parameter int MAX_PAYLOAD = cpd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_has_payload,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_control_value,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CW = $clog2(MAX_PAYLOAD + 1);

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_LEN    = 3'd1;
   localparam logic [2:0] PH_CTRL   = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_CRC_HI = 3'd4;
   localparam logic [2:0] PH_CRC_LO = 3'd5;

   logic [7:0]    sync_ff;
   logic [15:0]   seed_ff;
   logic [2:0]    phase_ff, phase_in;
   logic [CW-1:0] expected_ff, expected_in;
   logic [CW-1:0] taken_ff, taken_in;
   logic [7:0]    control_ff, control_in;
   logic [7:0]    crc_hi_ff, crc_hi_in;
   logic          stream_ff, stream_in;
   logic          avail_ff, avail_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_has_ff, rsp_has_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [7:0]    rsp_ctrl_ff, rsp_ctrl_in;
   logic          rsp_last_ff, rsp_last_in;

   cpd_pkg::crc_ctrl_type crc_ctrl;
   logic          crc_busy;
   logic [15:0]   crc_value;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_q;

   logic          req_accept, out_free, len_bad;
   logic [CW-1:0] taken_next, idx_next;

   cpd_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .busy  (crc_busy),
      .crc   (crc_value)
   );

   cpd_payload_ram #(
      .DEPTH (MAX_PAYLOAD),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_rx_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall  = crc_busy | stream_ff | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign taken_next = taken_ff + CW'(1);
   assign idx_next   = idx_ff + CW'(1);
   assign len_bad    = (req_rx_byte < 8'(cpd_pkg::HDR_LEN)) ||
                       ({1'b0, req_rx_byte} > 9'(MAX_PAYLOAD + cpd_pkg::HDR_LEN));
   assign ram_waddr  = taken_ff[AW-1:0];

   always_comb begin
      phase_in      = phase_ff;
      expected_in   = expected_ff;
      taken_in      = taken_ff;
      control_in    = control_ff;
      crc_hi_in     = crc_hi_ff;
      stream_in     = stream_ff;
      avail_in      = avail_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_ctrl_in   = rsp_ctrl_ff;
      rsp_last_in   = rsp_last_ff;
      crc_ctrl      = '0;
      crc_ctrl.seed = seed_ff;
      crc_ctrl.data = req_rx_byte;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         if (req_action) begin
            phase_in = PH_HUNT;
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (req_rx_byte == sync_ff) begin
                     phase_in           = PH_LEN;
                     taken_in           = '0;
                     crc_ctrl.load_seed = 1'b1;
                  end
               end
               PH_LEN: begin
                  if (len_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = cpd_pkg::ST_LEN;
                     rsp_has_in    = 1'b0;
                     rsp_byte_in   = '0;
                     rsp_ctrl_in   = '0;
                     rsp_last_in   = 1'b1;
                     phase_in      = PH_HUNT;
                  end else begin
                     expected_in = CW'(req_rx_byte - 8'(cpd_pkg::HDR_LEN));
                     phase_in    = PH_CTRL;
                  end
               end
               PH_CTRL: begin
                  control_in = req_rx_byte;
                  phase_in   = (expected_ff == '0) ? PH_CRC_HI : PH_DATA;
               end
               PH_DATA: begin
                  ram_we         = 1'b1;
                  crc_ctrl.start = 1'b1;
                  taken_in       = taken_next;
                  if (taken_next >= expected_ff) begin
                     phase_in = PH_CRC_HI;
                  end
               end
               PH_CRC_HI: begin
                  crc_hi_in = req_rx_byte;
                  phase_in  = PH_CRC_LO;
               end
               PH_CRC_LO: begin
                  phase_in = PH_HUNT;
                  if ({crc_hi_ff, req_rx_byte} != crc_value) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = cpd_pkg::ST_CRC;
                     rsp_has_in    = 1'b0;
                     rsp_byte_in   = '0;
                     rsp_ctrl_in   = control_ff;
                     rsp_last_in   = 1'b1;
                  end else if (expected_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = cpd_pkg::ST_GOOD;
                     rsp_has_in    = 1'b0;
                     rsp_byte_in   = '0;
                     rsp_ctrl_in   = control_ff;
                     rsp_last_in   = 1'b1;
                  end else begin
                     stream_in = 1'b1;
                     avail_in  = 1'b1;
                     idx_in    = '0;
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end

      // payload burst out of the memory
      if (avail_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cpd_pkg::ST_GOOD;
         rsp_has_in    = 1'b1;
         rsp_byte_in   = ram_q;
         rsp_ctrl_in   = control_ff;
         rsp_last_in   = (idx_next == expected_ff);
         if (idx_next == expected_ff) begin
            stream_in = 1'b0;
            avail_in  = 1'b0;
         end else begin
            idx_in    = idx_next;
            ram_re    = 1'b1;
            ram_raddr = idx_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= cpd_pkg::SYNC_RESET;
         seed_ff <= cpd_pkg::SEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cpd_pkg::CSR_SYNC: sync_ff <= csr_wdata[7:0];
            cpd_pkg::CSR_SEED: seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         expected_ff  <= '0;
         taken_ff     <= '0;
         control_ff   <= '0;
         crc_hi_ff    <= '0;
         stream_ff    <= 1'b0;
         avail_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         expected_ff  <= expected_in;
         taken_ff     <= taken_in;
         control_ff   <= control_in;
         crc_hi_ff    <= crc_hi_in;
         stream_ff    <= stream_in;
         avail_ff     <= avail_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_ctrl_ff   <= rsp_ctrl_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_has_payload   = rsp_has_ff;
   assign rsp_payload_byte  = rsp_byte_ff;
   assign rsp_control_value = rsp_ctrl_ff;
   assign rsp_last          = rsp_last_ff;

   a_crc_busy_phase: assert property (@(posedge clock) disable iff (reset)
      crc_busy |-> (phase_ff == PH_DATA || phase_ff == PH_CRC_HI))
      else $error("crc shifter busy outside payload phase");

   a_avail_in_stream: assert property (@(posedge clock) disable iff (reset)
      avail_ff |-> (stream_ff && idx_ff < expected_ff))
      else $error("memory data pending outside a payload burst");

   a_payload_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_has_ff) |-> (rsp_status_ff == cpd_pkg::ST_GOOD))
      else $error("payload byte on a failed frame");

   a_burst_ends_last: assert property (@(posedge clock) disable iff (reset)
      (stream_ff && !stream_in) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("payload burst ended without last");

endmodule
